// ----- rtl/core/dtmf_nibble_frame_receiver_macros.svh -----
// assertion macros used by the frame receiver assembler
`ifndef DTMF_NIBBLE_FRAME_RECEIVER_MACROS_SVH
`define DTMF_NIBBLE_FRAME_RECEIVER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define DNFR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dnfr assertion failed");

// consequent must hold in the cycle after the antecedent
`define DNFR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dnfr assertion failed");

`endif

// ----- rtl/core/dnfr_pkg.sv -----
// types and constants of the dtmf nibble frame receiver
package dnfr_pkg;

    localparam int unsigned NIB_W       = 4;
    localparam int unsigned FRAME_LEN   = 9;
    localparam int unsigned STORED_LEN  = 8;
    localparam int unsigned SLOT_W      = 3;
    localparam int unsigned COUNT_W     = 4;
    localparam int unsigned IDLE_W      = 16;
    localparam int unsigned SIG_ID_W    = 12;
    localparam int unsigned VOLT_W      = 8;
    localparam int unsigned CURR_W      = 6;
    localparam int unsigned APB_ADDR_W  = 3;
    localparam int unsigned APB_DATA_W  = 32;

    localparam logic [IDLE_W-1:0]  TIMEOUT_RESET = 16'd100;
    localparam logic [COUNT_W-1:0] LAST_COUNT    = 4'(FRAME_LEN - 1);

    // register index, taken from paddr bit 2
    typedef enum logic [0:0] {
        REG_IDLE_TIMEOUT = 1'b0,
        REG_UNUSED       = 1'b1
    } t_reg_index;

    typedef enum logic [0:0] {
        OP_STROBE = 1'b0,
        OP_TICK   = 1'b1
    } t_opcode;

    typedef struct packed {
        logic [SIG_ID_W-1:0] signal_id;
        logic [VOLT_W-1:0]   voltage_code;
        logic [CURR_W-1:0]   current_code;
        logic                alarm;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result data;
    } t_result_req;

    typedef struct packed {
        logic free;
    } t_out_status;

endpackage

// ----- rtl/core/dnfr_if.sv -----
// request channels of the frame receiver: decoder items in, frame results out
interface dnfr_in_if import dnfr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [NIB_W-1:0]  tone_nibble;
    logic              sender_busy;

    modport source (output valid, output opcode, output tone_nibble, output sender_busy,
                    input ready);
    modport sink   (input valid, input opcode, input tone_nibble, input sender_busy,
                    output ready);
endinterface

interface dnfr_out_if import dnfr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SIG_ID_W-1:0] signal_id;
    logic [VOLT_W-1:0]   voltage_code;
    logic [CURR_W-1:0]   current_code;
    logic                alarm;

    modport source (output valid, output signal_id, output voltage_code,
                    output current_code, output alarm, input ready);
    modport sink   (input valid, input signal_id, input voltage_code,
                    input current_code, input alarm, output ready);
endinterface

// ----- rtl/core/dnfr_apb_regs.sv -----
// apb configuration register: idle timeout
module dnfr_apb_regs import dnfr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [IDLE_W-1:0]     o_idle_timeout
);

    logic [IDLE_W-1:0] r_timeout;
    logic [IDLE_W-1:0] n_timeout;
    t_reg_index        reg_sel;
    logic              wr_en;

    assign reg_sel = t_reg_index'(paddr[2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb begin
        n_timeout = r_timeout;
        if (wr_en && (reg_sel == REG_IDLE_TIMEOUT)) begin
            n_timeout = pwdata[IDLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else begin
            r_timeout <= n_timeout;
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_IDLE_TIMEOUT: prdata = {{(APB_DATA_W-IDLE_W){1'b0}}, r_timeout};
            default:          prdata = '0;
        endcase
    end

    assign o_idle_timeout = r_timeout;

endmodule

// ----- rtl/core/dnfr_assembler.sv -----
// input register and frame assembly: nibble store, running sum, idle timer
`include "dtmf_nibble_frame_receiver_macros.svh"
module dnfr_assembler import dnfr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dnfr_in_if.sink           i_item,
    input  logic [IDLE_W-1:0] i_idle_timeout,
    input  t_out_status       i_out_status,
    output t_result_req       o_result
);

    // input register
    logic              r_in_valid;
    t_opcode           r_op;
    logic [NIB_W-1:0]  r_nib;
    logic              r_busy;

    // frame state
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic [NIB_W-1:0]   r_sum;
    logic [NIB_W-1:0]   n_sum;
    logic [IDLE_W-1:0]  r_idle;
    logic [IDLE_W-1:0]  n_idle;
    logic [NIB_W-1:0]   r_slot [1:STORED_LEN-1];

    logic              strobe;
    logic              take;
    logic              last;
    logic              emit;
    logic              fire;
    logic              accept;
    logic [NIB_W-1:0]  sum_next;
    logic [IDLE_W-1:0] idle_inc;
    logic [SLOT_W-1:0] slot_idx;

    assign strobe   = (r_op == OP_STROBE) && !r_busy;
    // a frame only opens on a zero nibble
    assign take     = strobe && ((r_count != '0) || (r_nib == '0));
    assign last     = take && (r_count == LAST_COUNT);
    assign sum_next = r_sum + r_nib;
    assign emit     = last && (sum_next == '0);
    assign fire     = r_in_valid && (!emit || i_out_status.free);
    assign accept   = i_item.valid && i_item.ready;
    assign idle_inc = (r_idle == '1) ? r_idle : r_idle + 1'b1;
    assign slot_idx = r_count[SLOT_W-1:0];

    assign i_item.ready = !r_in_valid || fire;

    always_comb begin
        n_count = r_count;
        n_sum   = r_sum;
        n_idle  = r_idle;
        if (fire) begin
            if (r_op == OP_TICK) begin
                if (r_count != '0) begin
                    n_idle = idle_inc;
                    if (idle_inc >= i_idle_timeout) begin
                        n_count = '0;
                        n_sum   = '0;
                    end
                end
            end else if (!r_busy) begin
                n_idle = '0;
                if (last) begin
                    n_count = '0;
                    n_sum   = '0;
                end else if (take) begin
                    n_count = r_count + 1'b1;
                    n_sum   = sum_next;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_count    <= '0;
            r_sum      <= '0;
            r_idle     <= '0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            r_count <= n_count;
            r_sum   <= n_sum;
            r_idle  <= n_idle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= t_opcode'(i_item.opcode);
            r_nib  <= i_item.tone_nibble;
            r_busy <= i_item.sender_busy;
        end
    end

    // slot 0 always holds the start zero, so it is not kept
    always_ff @(posedge i_clk) begin
        if (fire && take && (r_count != '0) && (r_count < COUNT_W'(STORED_LEN))) begin
            r_slot[slot_idx] <= r_nib;
        end
    end

    always_comb begin
        o_result.valid             = fire && emit;
        o_result.data.signal_id    = {r_slot[2], r_slot[3], 1'b0, r_slot[1][3:1]};
        o_result.data.voltage_code = {r_slot[5], r_slot[4]};
        o_result.data.current_code = {r_slot[6][3:2], r_slot[7]};
        o_result.data.alarm        = r_slot[6][0];
    end

    `DNFR_ASSERT_NEXT(a_frame_end_restarts, fire && last, r_count == '0 && r_sum == '0)
    `DNFR_ASSERT_NEXT(a_busy_strobe_ignored, fire && (r_op == OP_STROBE) && r_busy,
                      $stable(r_count) && $stable(r_sum) && $stable(r_idle))
    `DNFR_ASSERT_NEXT(a_tick_counts_idle, fire && (r_op == OP_TICK) && (r_count != '0),
                      r_idle != '0)

endmodule

// ----- rtl/core/dnfr_out_reg.sv -----
// result register towards the downstream sink
module dnfr_out_reg import dnfr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_result_req i_result,
    output t_out_status o_status,
    dnfr_out_if.source  o_result
);

    logic    r_valid;
    t_result r_data;

    assign o_status.free = !r_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_status.free) begin
            r_valid <= i_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_status.free && i_result.valid) begin
            r_data <= i_result.data;
        end
    end

    assign o_result.valid        = r_valid;
    assign o_result.signal_id    = r_data.signal_id;
    assign o_result.voltage_code = r_data.voltage_code;
    assign o_result.current_code = r_data.current_code;
    assign o_result.alarm        = r_data.alarm;

endmodule

// ----- rtl/core/dtmf_nibble_frame_receiver.sv -----
// top level of the dtmf nibble frame receiver
//
// i_item carries one request per cycle while ready: opcode 0 is a decoder
// strobe with tone_nibble and sender_busy, opcode 1 is one idle timer
// tick. o_result gives one request per nine-nibble frame that opens with
// a zero nibble and whose nibbles sum to zero mod 16: signal id, voltage,
// current and alarm. idle timeout is set through the apb port at byte
// address 0 (reset 100); write it only while no request is in flight.
// throughput is one request per cycle while the input is not stalled. a
// request is held in the input register, where the frame state and
// result are formed; the result is then loaded into the output register,
// which offers the frame result to the sink.
// reset clears the frame count, sum, idle timer and both valid flags; the
// stored nibbles keep whatever they hold.
// when the sink stalls, the result stays in the output register; requests
// that give no result keep flowing, one finishing frame waits in the input
// register and the input then stalls until the result is taken.
module dtmf_nibble_frame_receiver import dnfr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    dnfr_in_if.sink               i_item,
    dnfr_out_if.source            o_result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [IDLE_W-1:0] idle_timeout;
    t_result_req       result_req;
    t_out_status       out_status;

    dnfr_apb_regs u_regs (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_idle_timeout (idle_timeout)
    );

    dnfr_assembler u_asm (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (i_item),
        .i_idle_timeout (idle_timeout),
        .i_out_status   (out_status),
        .o_result       (result_req)
    );

    dnfr_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_result (result_req),
        .o_status (out_status),
        .o_result (o_result)
    );

endmodule
